// File: sv/e2q_pkg.sv
package e2q_pkg;

	localparam int AtanSteps = 24;
	localparam logic [63:0] PhasePerRadHalf = 64'd22399066950089;
	localparam logic [63:0] PhasePerDegHalf = 64'd390937467654;
	localparam logic [31:0] GainQ30 = 32'd652032874;

	typedef enum logic [2:0] {
		ORD_XYZ = 3'd0,
		ORD_XZY = 3'd1,
		ORD_YXZ = 3'd2,
		ORD_YZX = 3'd3,
		ORD_ZXY = 3'd4,
		ORD_ZYX = 3'd5
	} order_t;

	localparam logic [2:0] RegOrder = 3'd0;
	localparam logic [2:0] RegDegrees = 3'd1;

	typedef struct packed {
		logic [1:0] ax0;
		logic [1:0] ax1;
		logic [1:0] ax2;
	} axis_seq_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'd536870912;
			1: t = 32'd316933406;
			2: t = 32'd167458907;
			3: t = 32'd85004756;
			4: t = 32'd42667331;
			5: t = 32'd21354465;
			6: t = 32'd10679838;
			7: t = 32'd5340245;
			8: t = 32'd2670163;
			9: t = 32'd1335087;
			10: t = 32'd667544;
			11: t = 32'd333772;
			12: t = 32'd166886;
			13: t = 32'd83443;
			14: t = 32'd41722;
			15: t = 32'd20861;
			16: t = 32'd10430;
			17: t = 32'd5215;
			18: t = 32'd2608;
			19: t = 32'd1304;
			20: t = 32'd652;
			21: t = 32'd326;
			22: t = 32'd163;
			23: t = 32'd81;
			default: t = 32'd0;
		endcase
		return t;
	endfunction

	function automatic axis_seq_t order_seq(input logic [2:0] ord);
		axis_seq_t s;
		case (ord)
			ORD_XYZ: s = '{2'd0, 2'd1, 2'd2};
			ORD_XZY: s = '{2'd0, 2'd2, 2'd1};
			ORD_YZX: s = '{2'd1, 2'd2, 2'd0};
			ORD_ZXY: s = '{2'd2, 2'd0, 2'd1};
			ORD_ZYX: s = '{2'd2, 2'd1, 2'd0};
			default: s = '{2'd1, 2'd0, 2'd2};
		endcase
		return s;
	endfunction

endpackage

// File: sv/e2q_fifo.sv
module e2q_fifo #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [Width-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [Width-1:0] out_data
);
	localparam int Aw = $clog2(Depth);

	logic [Width-1:0] mem_q [Depth];
	logic [Aw-1:0]    wr_q;
	logic [Aw-1:0]    rd_q;
	logic [Aw:0]      cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = cnt_q != Depth[Aw:0];
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {{Aw{1'b0}}, push} - {{Aw{1'b0}}, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Depth[Aw:0]) else $error("queue count over depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("push lost");
	a_pop_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("pop lost");

endmodule

// File: sv/e2q_front.sv
module e2q_front
	import e2q_pkg::*;
#(
	parameter int SincosIterations = 16,
	parameter int FractionBits = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       degrees,
	input  logic [2:0]                 order,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [95:0]                in_angles,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [6*FractionBits+17:0] out_data
);
	localparam int Fb = FractionBits;
	localparam int Ns = (SincosIterations < AtanSteps) ? SincosIterations : AtanSteps;
	localparam int Cw = Fb + 3;
	localparam int Sw = 2 * Fb + 6;
	localparam int Ow = 6 * Fb + 18;

	// s0 split phase multiply, s1 phase sum and fold, then cordic, last stage sign and order
	logic                  v_s0;
	logic signed [55:0]    ml_s0 [3];
	logic signed [55:0]    mh_s0 [3];
	axis_seq_t             seq_s0;
	logic                  v_s1;
	logic [2:0][31:0]      ph_s1;
	logic [2:0]            flip_s1;
	axis_seq_t             seq_s1;
	logic                  v_s [Ns+1];
	logic signed [Cw-1:0]  x_s [Ns+1][3];
	logic signed [Cw-1:0]  y_s [Ns+1][3];
	logic signed [32:0]    z_s [Ns+1][3];
	logic [2:0]            fl_s [Ns+1];
	axis_seq_t             sq_s [Ns+1];
	logic                  v_o_q;
	logic [Ow-1:0]         d_o_q;
	logic                  adv;
	logic [44:0]           k;

	assign adv      = !v_o_q || out_ready;
	assign in_ready = adv;
	assign k        = degrees ? PhasePerDegHalf[44:0] : PhasePerRadHalf[44:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s0 <= in_valid;
			v_s1 <= v_s0;
		end
	end

	// angle times phase constant as two partial products, low 23 and high 22 bits of k
	always_ff @(posedge clk) begin
		logic signed [31:0] a;
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				a         = in_angles[32*j +: 32];
				ml_s0[j] <= 56'(a * signed'({1'b0, k[22:0]}));
				mh_s0[j] <= 56'(a * signed'({1'b0, k[44:23]}));
			end
			seq_s0 <= order_seq(order);
		end
	end

	always_ff @(posedge clk) begin
		logic [63:0] p;
		logic [31:0] ph;
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				p  = 64'(ml_s0[j]) + (64'(mh_s0[j]) << 23) + 64'h8000_0000;
				ph = p[63:32];
				flip_s1[j] <= ph[31] ^ ph[30];
				ph_s1[j]   <= (ph[31] ^ ph[30]) ? ph + 32'h8000_0000 : ph;
			end
			seq_s1 <= seq_s0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= Ns; i++) begin
				v_s[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s[0] <= v_s1;
			for (int i = 1; i <= Ns; i++) begin
				v_s[i] <= v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] g;
		if (adv) begin
			g = (GainQ30 + (32'd1 << (29 - Fb))) >> (30 - Fb);
			for (int j = 0; j < 3; j++) begin
				x_s[0][j] <= Cw'(signed'({1'b0, g}));
				y_s[0][j] <= '0;
				z_s[0][j] <= {ph_s1[j][31], ph_s1[j]};
			end
			fl_s[0] <= flip_s1;
			sq_s[0] <= seq_s1;
			for (int i = 0; i < Ns; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (!z_s[i][j][32]) begin
						x_s[i+1][j] <= x_s[i][j] - (y_s[i][j] >>> i);
						y_s[i+1][j] <= y_s[i][j] + (x_s[i][j] >>> i);
						z_s[i+1][j] <= z_s[i][j] - signed'({1'b0, atan_turn(i)});
					end else begin
						x_s[i+1][j] <= x_s[i][j] + (y_s[i][j] >>> i);
						y_s[i+1][j] <= y_s[i][j] - (x_s[i][j] >>> i);
						z_s[i+1][j] <= z_s[i][j] + signed'({1'b0, atan_turn(i)});
					end
				end
				fl_s[i+1] <= fl_s[i];
				sq_s[i+1] <= sq_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o_q <= 1'b0;
		end else if (adv) begin
			v_o_q <= v_s[Ns];
		end
	end

	// per slot: cos, sin (fb+2 bits each), axis
	always_ff @(posedge clk) begin
		logic signed [Cw-1:0] c;
		logic signed [Cw-1:0] s;
		logic [1:0] ax;
		if (adv) begin
			for (int n = 0; n < 3; n++) begin
				ax = (n == 0) ? sq_s[Ns].ax0 : (n == 1) ? sq_s[Ns].ax1 : sq_s[Ns].ax2;
				c  = fl_s[Ns][ax] ? -x_s[Ns][ax] : x_s[Ns][ax];
				s  = fl_s[Ns][ax] ? -y_s[Ns][ax] : y_s[Ns][ax];
				d_o_q[n*Sw +: Sw] <= {ax, s[Fb+1:0], c[Fb+1:0]};
			end
		end
	end

	assign out_valid = v_o_q;
	assign out_data  = d_o_q;

endmodule

// File: sv/e2q_back.sv
module e2q_back
	import e2q_pkg::*;
#(
	parameter int FractionBits = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [6*FractionBits+17:0] in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [71:0]                out_data
);
	localparam int Fb = FractionBits;
	localparam int Qw = Fb + 3;
	localparam int Pw = 2 * Qw + 3;
	localparam int Sw = 2 * Fb + 6;

	typedef logic signed [Qw-1:0] qv_t [4];

	logic   v_s1, v_s2, v_s3, v_s4, v_s5;
	qv_t    a_s1, b_s1, c_s1, c_s2, c_s3, r1_s3, r2_s5;
	logic signed [Pw-1:0] p1_s2 [4];
	logic signed [Pw-1:0] p2_s4 [4];
	logic   adv;

	assign adv      = !v_s5 || out_ready;
	assign in_ready = adv;

	function automatic qv_t unpack(input logic [2*Fb+5:0] d);
		qv_t q;
		logic signed [Fb+1:0] c;
		logic signed [Fb+1:0] s;
		logic [1:0] ax;
		c  = d[Fb+1:0];
		s  = d[2*Fb+3:Fb+2];
		ax = d[2*Fb+5 -: 2];
		q[0] = Qw'(c);
		q[1] = (ax == 2'd0) ? Qw'(s) : '0;
		q[2] = (ax == 2'd1) ? Qw'(s) : '0;
		q[3] = (ax == 2'd2) ? Qw'(s) : '0;
		return q;
	endfunction

	function automatic logic signed [Pw-1:0] mul(input logic signed [Qw-1:0] p,
			input logic signed [Qw-1:0] q);
		return Pw'(p * q);
	endfunction

	function automatic qv_t rnd(input logic signed [Pw-1:0] v [4]);
		qv_t r;
		logic signed [Pw-1:0] t;
		for (int i = 0; i < 4; i++) begin
			t    = (v[i] + (Pw'(1) <<< (Fb - 1))) >>> Fb;
			r[i] = Qw'(t);
		end
		return r;
	endfunction

	function automatic logic [17:0] to_q16(input logic signed [Qw-1:0] v);
		logic signed [Qw+16:0] r;
		if (Fb > 16) begin
			r = (Qw+17)'((v + (Qw'(1) <<< (Fb - 17))) >>> (Fb - 16));
		end else begin
			r = (Qw+17)'(v) <<< (16 - Fb);
		end
		if (r > 65536) begin
			r = (Qw+17)'(65536);
		end else if (r < -65536) begin
			r = (Qw+17)'(-65536);
		end
		return r[17:0];
	endfunction

	function automatic void ham(input qv_t a, input qv_t b,
			output logic signed [Pw-1:0] o [4]);
		o[0] = mul(a[0], b[0]) - mul(a[1], b[1]) - mul(a[2], b[2]) - mul(a[3], b[3]);
		o[1] = mul(a[0], b[1]) + mul(a[1], b[0]) + mul(a[2], b[3]) - mul(a[3], b[2]);
		o[2] = mul(a[0], b[2]) - mul(a[1], b[3]) + mul(a[2], b[0]) + mul(a[3], b[1]);
		o[3] = mul(a[0], b[3]) + mul(a[1], b[2]) - mul(a[2], b[1]) + mul(a[3], b[0]);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [Pw-1:0] t1 [4];
		logic signed [Pw-1:0] t2 [4];
		if (adv) begin
			a_s1 <= unpack(in_data[0 +: Sw]);
			b_s1 <= unpack(in_data[Sw +: Sw]);
			c_s1 <= unpack(in_data[2*Sw +: Sw]);
			ham(a_s1, b_s1, t1);
			p1_s2 <= t1;
			c_s2  <= c_s1;
			r1_s3 <= rnd(p1_s2);
			c_s3  <= c_s2;
			ham(r1_s3, c_s3, t2);
			p2_s4 <= t2;
			r2_s5 <= rnd(p2_s4);
		end
	end

	assign out_valid = v_s5;
	assign out_data  = {to_q16(r2_s5[3]), to_q16(r2_s5[2]), to_q16(r2_s5[1]),
		to_q16(r2_s5[0])};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !out_ready) |=> v_s5) else $error("result dropped");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s5 |-> in_ready) else $error("stall without result");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s4) |=> v_s5) else $error("stage lost");

endmodule

// File: sv/euler_to_quaternion.sv
// channel   dir  width  fields
// s_axis    in   96     angle_x, angle_y, angle_z
// m_axis    out  72     quat_w, quat_x, quat_y, quat_z
// apb       in   32     rotation_order @0, angle_in_degrees @4
// one item per cycle unless m_axis stalls; the path runs through two phase
// multiply stages, SINCOS_ITERATIONS + 1 cordic stages (iterations capped
// at AtanSteps), the sign stage, the queue register and five product stages
// arst_n clears valids and registers to YXZ, radians
// back stall fills the queue, then holds the front stages
module euler_to_quaternion
	import e2q_pkg::*;
#(
	parameter int SINCOS_ITERATIONS = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // angle_x, angle_y, angle_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // quat_w, quat_x, quat_y, quat_z
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int Dw = 6 * FRACTION_BITS + 18;

	logic [2:0]    order_q;
	logic          deg_q;
	logic          f_valid, f_ready, b_valid, b_ready;
	logic [Dw-1:0] f_data, b_data;
	logic          wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORD_YXZ;
			deg_q   <= 1'b0;
		end else if (wr) begin
			if (paddr[2] == RegDegrees[0]) begin
				deg_q <= pwdata[0];
			end else begin
				order_q <= pwdata[2:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == RegDegrees[0]) begin
			prdata[0] = deg_q;
		end else begin
			prdata[2:0] = order_q;
		end
	end

	e2q_front #(.SincosIterations(SINCOS_ITERATIONS), .FractionBits(FRACTION_BITS)) u_front (
		.clk, .arst_n, .degrees(deg_q), .order(order_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_angles(s_axis_tdata),
		.out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
	);

	e2q_fifo #(.Width(Dw), .Depth(4)) u_fifo (
		.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
	);

	e2q_back #(.FractionBits(FRACTION_BITS)) u_back (
		.clk, .arst_n, .in_valid(b_valid), .in_ready(b_ready), .in_data(b_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);

endmodule
